/* hw/rtl/bzf_pkg.sv */
// Shared types, constants and fixed-point helpers for the Bezier flattener.
// Used by bzf_weight, bzf_lane, bzf_merge and bezier_uniform_flatten_top.
package bzf_pkg;

    localparam int W_N     = 6;    // segment count width
    localparam int W_T     = 17;   // unsigned Q1.16 parameter and weight products
    localparam int W_W     = 18;   // scaled Bernstein weight
    localparam int W_C     = 32;   // signed Q16.16 coordinate
    localparam int W_TERM  = 35;   // one rounded weight*coordinate term
    localparam int W_SUM   = 37;   // exact sum of four terms
    localparam int N_LANES = 4;
    localparam int W_DCNT  = 5;

    localparam logic [W_T-1:0]    ONE_Q16   = 17'h10000;
    localparam logic [W_DCNT-1:0] DIV_LAST  = 5'd16;   // 17 restoring steps
    localparam logic [W_N-1:0]    SEG_RESET = 6'd16;
    localparam logic              OP_QUAD   = 1'b0;
    localparam logic              OP_CUBIC  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN
    } bzf_state_t;

    typedef struct packed {
        logic valid;
        logic last;
    } bzf_ctl_t;

    typedef logic [N_LANES-1:0][W_W-1:0]    bzf_wvec_t;
    typedef logic [N_LANES-1:0][W_TERM-1:0] bzf_tvec_t;

    // Rounded Q1.16 product: (a*b + 0.5) >> 16
    function automatic logic [W_T-1:0] wmul(input logic [W_T-1:0] a, input logic [W_T-1:0] b);
        logic [2*W_T-1:0] p;
        begin
            p = {{W_T{1'b0}}, a} * {{W_T{1'b0}}, b} + 34'd32768;
            return p[W_T+15:16];
        end
    endfunction

endpackage

/* hw/rtl/bzf_weight.sv */
// Two-stage Bernstein weight unit: t -> (tt, uu, ut) -> cubic or quadratic weights.
// Depends on bzf_pkg.
module bzf_weight import bzf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  bzf_ctl_t       in_ctl,
    input  logic [W_T-1:0] t,
    input  logic           op,
    output bzf_ctl_t       out_ctl,
    output bzf_wvec_t      w,
    output logic           busy
);

    bzf_ctl_t        ctl2_reg, ctl2_next;
    bzf_ctl_t        ctl3_reg, ctl3_next;
    logic [W_T-1:0]  t2_reg, u2_reg, tt2_reg, uu2_reg, ut2_reg;
    logic [W_T-1:0]  u1;
    bzf_wvec_t       w3_reg, w3_next;
    logic [W_T-1:0]  p_uuu, p_uut, p_utt, p_ttt;

    assign u1 = ONE_Q16 - t;

    always_comb
    begin
        ctl2_next = adv ? in_ctl : ctl2_reg;
        ctl3_next = adv ? ctl2_reg : ctl3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl2_next;
            ctl3_reg <= ctl3_next;
        end
    end

    // stage 1: square and cross products of t and u
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t2_reg  <= t;
            u2_reg  <= u1;
            tt2_reg <= wmul(t, t);
            uu2_reg <= wmul(u1, u1);
            ut2_reg <= wmul(u1, t);
        end
    end

    // stage 2: third-order products, then pick the weight set
    always_comb
    begin
        p_uuu   = wmul(uu2_reg, u2_reg);
        p_uut   = wmul(uu2_reg, t2_reg);
        p_utt   = wmul(u2_reg, tt2_reg);
        p_ttt   = wmul(tt2_reg, t2_reg);
        w3_next = '0;
        unique case (op)
            OP_CUBIC:
            begin
                w3_next[0] = {1'b0, p_uuu};
                w3_next[1] = {p_uut, 1'b0} + {1'b0, p_uut};
                w3_next[2] = {p_utt, 1'b0} + {1'b0, p_utt};
                w3_next[3] = {1'b0, p_ttt};
            end
            OP_QUAD:
            begin
                w3_next[0] = {1'b0, uu2_reg};
                w3_next[1] = {ut2_reg, 1'b0};
                w3_next[2] = {1'b0, tt2_reg};
                w3_next[3] = '0;
            end
            default:
            begin
                w3_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w3_reg <= w3_next;
        end
    end

    assign out_ctl = ctl3_reg;
    assign w       = w3_reg;
    assign busy    = ctl2_reg.valid | ctl3_reg.valid;

endmodule

/* hw/rtl/bzf_lane.sv */
// One lane: rounds weight*coordinate to Q16.16 for x and y of one control point.
// Depends on bzf_pkg.
module bzf_lane import bzf_pkg::*;
(
    input  logic                    clk,
    input  logic                    adv,
    input  logic [W_W-1:0]          w,
    input  logic signed [W_C-1:0]   px,
    input  logic signed [W_C-1:0]   py,
    output logic [W_TERM-1:0]       term_x,
    output logic [W_TERM-1:0]       term_y
);

    logic signed [W_W+W_C:0] prod_x, prod_y;
    logic signed [W_W+W_C:0] rnd_x, rnd_y;
    logic [W_TERM-1:0]       term_x_reg, term_y_reg;

    always_comb
    begin
        prod_x = $signed({1'b0, w}) * px;
        prod_y = $signed({1'b0, w}) * py;
        // floor((w*p + 0.5) / 1.0): arithmetic shift of the biased product
        rnd_x  = prod_x + 51'sd32768;
        rnd_y  = prod_y + 51'sd32768;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_x_reg <= rnd_x[W_W+W_C:16];
            term_y_reg <= rnd_y[W_W+W_C:16];
        end
    end

    assign term_x = term_x_reg;
    assign term_y = term_y_reg;

endmodule

/* hw/rtl/bzf_merge.sv */
// Merge stage: sums the lane terms, saturates to 32 bits and holds the output point.
// Depends on bzf_pkg.
module bzf_merge import bzf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  bzf_ctl_t              in_ctl,
    input  bzf_tvec_t             term_x,
    input  bzf_tvec_t             term_y,
    output logic                  out_valid,
    output logic signed [W_C-1:0] pt_x,
    output logic signed [W_C-1:0] pt_y,
    output logic                  last,
    output logic                  busy
);

    bzf_ctl_t          ctl4_reg, ctl4_next;
    logic              out_valid_reg, out_valid_next;
    logic [W_C-1:0]    pt_x_reg, pt_y_reg;
    logic              last_reg;
    logic [W_SUM-1:0]  sum_x, sum_y;
    logic [W_C-1:0]    sat_x, sat_y;

    function automatic logic [W_C-1:0] sat32(input logic [W_SUM-1:0] v);
        logic ovf;
        begin
            ovf = (v[W_SUM-1:W_C-1] != {(W_SUM-W_C+1){1'b0}})
                && (v[W_SUM-1:W_C-1] != {(W_SUM-W_C+1){1'b1}});
            if (!ovf)
                return v[W_C-1:0];
            else if (v[W_SUM-1])
                return {1'b1, {(W_C-1){1'b0}}};
            else
                return {1'b0, {(W_C-1){1'b1}}};
        end
    endfunction

    always_comb
    begin
        sum_x = '0;
        sum_y = '0;
        for (int k = 0; k < N_LANES; k++)
        begin
            sum_x = sum_x + {{(W_SUM-W_TERM){term_x[k][W_TERM-1]}}, term_x[k]};
            sum_y = sum_y + {{(W_SUM-W_TERM){term_y[k][W_TERM-1]}}, term_y[k]};
        end
        sat_x = sat32(sum_x);
        sat_y = sat32(sum_y);
    end

    always_comb
    begin
        ctl4_next      = adv ? in_ctl : ctl4_reg;
        out_valid_next = adv ? ctl4_reg.valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctl4_reg      <= ctl4_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctl4_reg.valid)
        begin
            pt_x_reg <= sat_x;
            pt_y_reg <= sat_y;
            last_reg <= ctl4_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pt_x      = pt_x_reg;
    assign pt_y      = pt_y_reg;
    assign last      = last_reg;
    assign busy      = ctl4_reg.valid;

endmodule

/* hw/rtl/bezier_uniform_flatten_top.sv */
// Uniform-parameter Bezier flattener, top level.
// Input channel (in_valid/in_ready) takes one curve: op selects quadratic (p0..p2)
// or cubic (p0..p3), coordinates signed Q16.16. Output channel (out_valid/out_ready)
// gives segment_count+1 points pt_x/pt_y at t = i/segment_count, last set on the
// final point. cfg_wr_en/cfg_wr_data write segment_count (zero acts as one); write
// it only while idle.
// Per curve: a bit-serial divider finds the parameter step 1/n, then one point enters
// the weight pipeline each cycle while the receiver does not stall. The first point
// passes the weight stages, a lane register and the merge output register; the next
// curve waits for the divider, the issue of all n + 1 points and the pipeline drain.
// Pipeline: 2 weight stages, 4 parallel lanes (one per control point), merge stage
// that sums, saturates and holds the output register.
// A stalled receiver freezes the whole point pipeline; nothing is dropped. A new
// curve is taken once the previous curve's points have all reached the output
// register. Reset empties the pipeline and sets segment_count to 16.
// Depends on bzf_pkg, bzf_weight, bzf_lane, bzf_merge.
module bezier_uniform_flatten_top import bzf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [W_N-1:0]        cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic signed [W_C-1:0] p0_x,
    input  logic signed [W_C-1:0] p0_y,
    input  logic signed [W_C-1:0] p1_x,
    input  logic signed [W_C-1:0] p1_y,
    input  logic signed [W_C-1:0] p2_x,
    input  logic signed [W_C-1:0] p2_y,
    input  logic signed [W_C-1:0] p3_x,
    input  logic signed [W_C-1:0] p3_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [W_C-1:0] pt_x,
    output logic signed [W_C-1:0] pt_y,
    output logic                  last
);

    bzf_state_t          state_reg, state_next;
    logic [W_N-1:0]      seg_reg, seg_next;
    logic [W_N-1:0]      n_reg;
    logic                op_reg;
    logic signed [W_C-1:0] px_reg [N_LANES];
    logic signed [W_C-1:0] py_reg [N_LANES];

    logic [W_DCNT-1:0]   div_cnt_reg, div_cnt_next;
    logic [W_T-1:0]      dq_reg, dq_next;      // dividend, then quotient 65536/n
    logic [W_N-1:0]      rem_reg, rem_next;    // remainder 65536 % n
    logic [W_T-1:0]      acc_q_reg, acc_q_next;
    logic [W_N-1:0]      acc_r_reg, acc_r_next;
    logic [W_N-1:0]      i_reg, i_next;

    logic                accept, adv, emit, last_pt, div_step, idle;
    logic [W_N:0]        rem_shift, r_sum;
    logic                rem_ge, r_wrap;
    logic                w_busy, m_busy;

    bzf_ctl_t            gen_ctl, w_ctl;
    bzf_wvec_t           wv;
    bzf_tvec_t           tx, ty;

    assign accept  = in_valid & in_ready;
    assign last_pt = (i_reg == n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DIV;
            ST_DIV:  if (div_cnt_reg == DIV_LAST) state_next = ST_RUN;
            ST_RUN:  if (emit && last_pt) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        idle     = 1'b0;
        div_step = 1'b0;
        emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: idle     = 1'b1;
            ST_DIV:  div_step = 1'b1;
            ST_RUN:  emit     = adv;
            default: idle     = 1'b0;
        endcase
    end

    assign adv      = ~out_valid | out_ready;
    assign in_ready = idle & ~w_busy & ~m_busy;

    // restoring divider, one quotient bit per cycle; point stepper
    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[W_T-1]};
        rem_ge    = rem_shift >= {1'b0, n_reg};
        r_sum     = {1'b0, acc_r_reg} + {1'b0, rem_reg};
        r_wrap    = r_sum >= {1'b0, n_reg};

        seg_next     = cfg_wr_en ? cfg_wr_data : seg_reg;
        div_cnt_next = div_cnt_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        acc_q_next   = acc_q_reg;
        acc_r_next   = acc_r_reg;
        i_next       = i_reg;

        if (accept)
        begin
            div_cnt_next = '0;
            dq_next      = ONE_Q16;
            rem_next     = '0;
        end
        else if (div_step)
        begin
            div_cnt_next = div_cnt_reg + 1'b1;
            dq_next      = {dq_reg[W_T-2:0], rem_ge};
            rem_next     = rem_ge ? W_N'(rem_shift - {1'b0, n_reg}) : rem_shift[W_N-1:0];
            // start the parameter at t = 0 with the half-step rounding bias
            acc_q_next   = '0;
            acc_r_next   = n_reg >> 1;
            i_next       = '0;
        end
        else if (emit)
        begin
            acc_q_next = acc_q_reg + dq_reg + {{(W_T-1){1'b0}}, r_wrap};
            acc_r_next = r_wrap ? W_N'(r_sum - {1'b0, n_reg}) : r_sum[W_N-1:0];
            i_next     = i_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seg_reg     <= SEG_RESET;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            seg_reg     <= seg_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        acc_q_reg <= acc_q_next;
        acc_r_reg <= acc_r_next;
        i_reg     <= i_next;
        if (accept)
        begin
            n_reg     <= (seg_reg == '0) ? W_N'(1) : seg_reg;
            op_reg    <= op;
            px_reg[0] <= p0_x;
            py_reg[0] <= p0_y;
            px_reg[1] <= p1_x;
            py_reg[1] <= p1_y;
            px_reg[2] <= p2_x;
            py_reg[2] <= p2_y;
            px_reg[3] <= p3_x;
            py_reg[3] <= p3_y;
        end
    end

    always_comb
    begin
        gen_ctl.valid = emit;
        gen_ctl.last  = last_pt;
    end

    bzf_weight u_weight (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_ctl  (gen_ctl),
        .t       (acc_q_reg),
        .op      (op_reg),
        .out_ctl (w_ctl),
        .w       (wv),
        .busy    (w_busy)
    );

    for (genvar k = 0; k < N_LANES; k++)
    begin : g_lane
        bzf_lane u_lane (
            .clk    (clk),
            .adv    (adv),
            .w      (wv[k]),
            .px     (px_reg[k]),
            .py     (py_reg[k]),
            .term_x (tx[k]),
            .term_y (ty[k])
        );
    end

    bzf_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_ctl    (w_ctl),
        .term_x    (tx),
        .term_y    (ty),
        .out_valid (out_valid),
        .pt_x      (pt_x),
        .pt_y      (pt_y),
        .last      (last),
        .busy      (m_busy)
    );

`ifndef SYNTHESIS
    // the divided step must land exactly on t = 1 at the final point
    a_last_t_one: assert property (@(posedge clk) disable iff (!rst_n)
        emit && last_pt |-> acc_q_reg == ONE_Q16)
        else $error("final point parameter is not one");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> acc_r_reg < n_reg && rem_reg < n_reg)
        else $error("step remainder out of range");

    a_accept_divides: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DIV && !in_ready)
        else $error("curve transaction did not start the divider");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (w_busy || m_busy || state_reg == ST_RUN) |-> !in_ready)
        else $error("input taken while points of a curve are in flight");
`endif

endmodule
